// File: rtl/core/wstd_pkg.sv
// Package for the work-stealing task dispatcher: command, response and
// worker state codes plus the sequencer state type. No dependencies.
`default_nettype none

package wstd_pkg;

   // Command codes on req_command
   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_REQUEST = 2'd1,
      CMD_SUSPEND = 2'd2,
      CMD_RESUME  = 2'd3
   } cmd_type;

   // Response status codes on rsp_status
   typedef enum logic [2:0] {
      RSP_DONE        = 3'd0,
      RSP_SLEPT       = 3'd1,
      RSP_NOT_WORKING = 3'd2,
      RSP_FULL        = 3'd3,
      RSP_NO_CHANGE   = 3'd4
   } rsp_status_type;

   // Per-worker run state
   typedef enum logic [1:0] {
      WK_WORKING   = 2'd0,
      WK_SLEEPING  = 2'd1,
      WK_SUSPENDED = 2'd2
   } worker_state_type;

   // Sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MOD,
      SEQ_ADD,
      SEQ_CHECK,
      SEQ_SCAN,
      SEQ_GROUP,
      SEQ_RESP
   } seq_state_type;

   localparam int unsigned CSR_BITS    = 4;
   localparam int unsigned CSR_RESET   = 8;
   localparam int unsigned ID_PORT_BITS = 16;

endpackage

`default_nettype wire

// File: rtl/core/work_stealing_task_dispatcher.sv
// Top level of the work-stealing task dispatcher: command sequencer, queue
// pointers and worker states. Depends on wstd_pkg and wstd_task_ram.
//
// Usage: drive req_command/req_worker/req_task_id and pulse start while
// busy is low; the transaction is taken at that edge and busy stays high
// until its response is out. Exactly one response per transaction appears
// for one cycle on the rsp_ ports, marked by rsp_strobe; the receiver has no
// way to stall it. csr_wr_en/csr_wr_data write workers_in_use (reset 8, 0 acts
// as 1); the user must do so only while busy is low; the block does not enforce this.
// Sequencer states, from the accepting edge to the strobe state RESP:
//   add:            MOD (held for each subtraction the round-robin pointer
//                   needs after workers_in_use was lowered), ADD, RESP.
//   request:        CHECK, RESP when the worker is not working, else CHECK,
//                   SCAN over s queues (s = queues scanned, 1..n), RESP; one
//                   queue per cycle through the shared index/compare unit.
//   suspend/resume: GROUP, RESP.
// busy drops the cycle after the strobe. Reset (synchronous) empties all
// queues, puts every worker to sleep and clears the round-robin pointer;
// the task memory is not cleared.
`default_nettype none

module work_stealing_task_dispatcher #(
   parameter int unsigned NUM_QUEUES   = 8,
   parameter int unsigned QUEUE_DEPTH  = 16,
   parameter int unsigned TASK_ID_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_worker,
   input  wire logic [15:0] req_task_id,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_task_out,
   output logic [2:0]       rsp_queue_used,
   output logic             rsp_wake
);

   localparam int unsigned QW = $clog2(NUM_QUEUES);
   localparam int unsigned NW = QW + 1;
   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SB = (TASK_ID_BITS < wstd_pkg::ID_PORT_BITS) ?
                                TASK_ID_BITS : wstd_pkg::ID_PORT_BITS;

   // control state
   wstd_pkg::seq_state_type    state_ff, state_in;
   wstd_pkg::cmd_type          cmd_ff, cmd_in;
   logic [3:0]                 wiu_ff;
   logic [QW-1:0]              cur_q_ff, cur_q_in;
   logic [NW-1:0]              cnt_ff, cnt_in;
   logic [QW-1:0]              next_q_ff, next_q_in;
   logic                       all_susp_ff, all_susp_in;
   logic [PW-1:0]              head_ff [NUM_QUEUES];
   logic [PW-1:0]              head_in [NUM_QUEUES];
   logic [PW-1:0]              tail_ff [NUM_QUEUES];
   logic [PW-1:0]              tail_in [NUM_QUEUES];
   logic [FW-1:0]              fill_ff [NUM_QUEUES];
   logic [FW-1:0]              fill_in [NUM_QUEUES];
   wstd_pkg::worker_state_type wstat_ff [NUM_QUEUES];
   wstd_pkg::worker_state_type wstat_in [NUM_QUEUES];

   // transaction payload and result registers
   logic [2:0]                 worker_ff, worker_in;
   logic [SB-1:0]              task_ff, task_in;
   wstd_pkg::rsp_status_type   res_status_ff, res_status_in;
   logic [2:0]                 res_qused_ff, res_qused_in;
   logic                       res_wake_ff, res_wake_in;
   logic                       popped_ff, popped_in;

   // memory port signals
   logic                       mem_we, mem_re;
   logic [QW+PW-1:0]           mem_waddr, mem_raddr;
   logic [SB-1:0]              mem_rdata;

   // shared index unit and current-queue views
   logic [7:0]                 wiu8, n8, worker8;
   logic [NW-1:0]              n_act;
   logic [NW-1:0]              q_ext, q_sub, q_plus;
   logic                       q_ge_n;
   logic [QW-1:0]              q_next, worker_q;
   logic [FW-1:0]              cur_fill;
   logic [PW-1:0]              cur_head, cur_tail, head_adv, tail_adv;
   wstd_pkg::worker_state_type cur_wstat;
   logic                       is_full, q_empty, w_bad, scan_last;
   logic [7:0]                 q8;

   // active worker count, clamped to 1..NUM_QUEUES
   assign wiu8 = {4'd0, wiu_ff};
   always_comb begin
      if (wiu_ff == 4'd0) begin
         n8 = 8'd1;
      end else if (wiu8 > 8'(NUM_QUEUES)) begin
         n8 = 8'(NUM_QUEUES);
      end else begin
         n8 = wiu8;
      end
   end
   assign n_act = NW'(n8);

   // shared compare/subtract/increment on the current queue index
   assign q_ext  = {1'b0, cur_q_ff};
   assign q_ge_n = (q_ext >= n_act);
   assign q_sub  = q_ext - n_act;
   assign q_plus = q_ext + NW'(1);
   assign q_next = (q_plus == n_act) ? '0 : QW'(q_plus);
   assign q8     = 8'(cur_q_ff);

   assign worker8  = {5'd0, worker_ff};
   assign worker_q = QW'({5'd0, req_worker});
   assign w_bad    = (worker8 >= n8) || (cur_wstat != wstd_pkg::WK_WORKING);

   assign cur_fill  = fill_ff[cur_q_ff];
   assign cur_head  = head_ff[cur_q_ff];
   assign cur_tail  = tail_ff[cur_q_ff];
   assign cur_wstat = wstat_ff[cur_q_ff];
   assign is_full   = (cur_fill == FW'(QUEUE_DEPTH));
   assign q_empty   = (cur_fill == '0);
   assign head_adv  = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);
   assign tail_adv  = (cur_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + PW'(1);
   assign scan_last = (NW'(cnt_ff + NW'(1)) == n_act);

   assign mem_waddr = {cur_q_ff, cur_tail};
   assign mem_raddr = {cur_q_ff, cur_head};

   wstd_task_ram #(
      .ADDR_BITS (QW + PW),
      .DATA_BITS (SB)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (task_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wstd_pkg::SEQ_IDLE: begin
            if (start) begin
               case (wstd_pkg::cmd_type'(req_command))
                  wstd_pkg::CMD_ADD:     state_in = wstd_pkg::SEQ_MOD;
                  wstd_pkg::CMD_REQUEST: state_in = wstd_pkg::SEQ_CHECK;
                  default:               state_in = wstd_pkg::SEQ_GROUP;
               endcase
            end
         end
         wstd_pkg::SEQ_MOD: begin
            if (!q_ge_n) state_in = wstd_pkg::SEQ_ADD;
         end
         wstd_pkg::SEQ_ADD:   state_in = wstd_pkg::SEQ_RESP;
         wstd_pkg::SEQ_CHECK: begin
            state_in = w_bad ? wstd_pkg::SEQ_RESP : wstd_pkg::SEQ_SCAN;
         end
         wstd_pkg::SEQ_SCAN: begin
            if (!q_empty || scan_last) state_in = wstd_pkg::SEQ_RESP;
         end
         wstd_pkg::SEQ_GROUP: state_in = wstd_pkg::SEQ_RESP;
         wstd_pkg::SEQ_RESP:  state_in = wstd_pkg::SEQ_IDLE;
         default:             state_in = wstd_pkg::SEQ_IDLE;
      endcase
   end

   // datapath and result values
   always_comb begin
      cmd_in        = cmd_ff;
      cur_q_in      = cur_q_ff;
      cnt_in        = cnt_ff;
      next_q_in     = next_q_ff;
      all_susp_in   = all_susp_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      wstat_in      = wstat_ff;
      worker_in     = worker_ff;
      task_in       = task_ff;
      res_status_in = res_status_ff;
      res_qused_in  = res_qused_ff;
      res_wake_in   = res_wake_ff;
      popped_in     = popped_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      case (state_ff)
         wstd_pkg::SEQ_IDLE: begin
            if (start) begin
               cmd_in        = wstd_pkg::cmd_type'(req_command);
               worker_in     = req_worker;
               task_in       = req_task_id[SB-1:0];
               cnt_in        = '0;
               res_status_in = wstd_pkg::RSP_DONE;
               res_qused_in  = 3'd0;
               res_wake_in   = 1'b0;
               popped_in     = 1'b0;
               cur_q_in      = (wstd_pkg::cmd_type'(req_command) == wstd_pkg::CMD_REQUEST) ?
                               worker_q : next_q_ff;
            end
         end
         // round-robin pointer mod n by repeated subtraction
         wstd_pkg::SEQ_MOD: begin
            if (q_ge_n) cur_q_in = QW'(q_sub);
         end
         wstd_pkg::SEQ_ADD: begin
            res_qused_in = q8[2:0];
            if (is_full) begin
               res_status_in = wstd_pkg::RSP_FULL;
            end else begin
               mem_we             = 1'b1;
               tail_in[cur_q_ff]  = tail_adv;
               fill_in[cur_q_ff]  = cur_fill + FW'(1);
               next_q_in          = q_next;
               if (q_empty && cur_wstat == wstd_pkg::WK_SLEEPING) begin
                  wstat_in[cur_q_ff] = wstd_pkg::WK_WORKING;
                  res_wake_in        = 1'b1;
               end
            end
         end
         wstd_pkg::SEQ_CHECK: begin
            res_qused_in = worker_ff;
            if (w_bad) res_status_in = wstd_pkg::RSP_NOT_WORKING;
         end
         // steal scan: one queue per cycle, starting at the own queue
         wstd_pkg::SEQ_SCAN: begin
            if (!q_empty) begin
               mem_re            = 1'b1;
               head_in[cur_q_ff] = head_adv;
               fill_in[cur_q_ff] = cur_fill - FW'(1);
               res_qused_in      = q8[2:0];
               popped_in         = 1'b1;
            end else if (scan_last) begin
               wstat_in[QW'(worker8)] = wstd_pkg::WK_SLEEPING;
               res_status_in          = wstd_pkg::RSP_SLEPT;
               res_qused_in           = worker_ff;
            end else begin
               cur_q_in = q_next;
               cnt_in   = NW'(cnt_ff + NW'(1));
            end
         end
         wstd_pkg::SEQ_GROUP: begin
            if ((cmd_ff == wstd_pkg::CMD_SUSPEND) == all_susp_ff) begin
               res_status_in = wstd_pkg::RSP_NO_CHANGE;
            end else begin
               all_susp_in = (cmd_ff == wstd_pkg::CMD_SUSPEND);
               for (int i = 0; i < NUM_QUEUES; i++) begin
                  if (NW'(i) < n_act) begin
                     wstat_in[i] = (cmd_ff == wstd_pkg::CMD_SUSPEND) ?
                                   wstd_pkg::WK_SUSPENDED : wstd_pkg::WK_WORKING;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wstd_pkg::SEQ_IDLE;
         wiu_ff      <= 4'(wstd_pkg::CSR_RESET);
         next_q_ff   <= '0;
         all_susp_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            wstat_ff[i] <= wstd_pkg::WK_SLEEPING;
         end
      end else begin
         state_ff    <= state_in;
         next_q_ff   <= next_q_in;
         all_susp_ff <= all_susp_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         wstat_ff    <= wstat_in;
         if (csr_wr_en) wiu_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_q_ff      <= cur_q_in;
      cnt_ff        <= cnt_in;
      worker_ff     <= worker_in;
      task_ff       <= task_in;
      res_status_ff <= res_status_in;
      res_qused_ff  <= res_qused_in;
      res_wake_ff   <= res_wake_in;
      popped_ff     <= popped_in;
   end

   // outputs
   assign busy           = (state_ff != wstd_pkg::SEQ_IDLE);
   assign rsp_strobe     = (state_ff == wstd_pkg::SEQ_RESP);
   assign rsp_status     = res_status_ff;
   assign rsp_task_out   = popped_ff ? 16'(mem_rdata) : 16'd0;
   assign rsp_queue_used = res_qused_ff;
   assign rsp_wake       = res_wake_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("response strobe longer than one cycle");

   // current queue index is only meaningful while a transaction is in flight
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> fill_ff[cur_q_ff] <= FW'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_full_no_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == wstd_pkg::RSP_FULL |-> !rsp_wake)
      else $error("wake reported on full queue");

   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != wstd_pkg::RSP_DONE |-> rsp_task_out == 16'd0)
      else $error("task id on a failed response");

endmodule

`default_nettype wire

// File: rtl/core/wstd_task_ram.sv
// Task id storage for all worker queues: one write port, one read port
// with registered read data. Uses no package.
`default_nettype none

module wstd_task_ram #(
   parameter int unsigned ADDR_BITS = 7,
   parameter int unsigned DATA_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: test/work_stealing_task_dispatcher_tb.sv
// Self-checking testbench for work_stealing_task_dispatcher: directed and random
// command streams, each response checked against an in-bench dispatch predictor.
// Depends on wstd_pkg and the dispatcher RTL.

module testbench;

   localparam int unsigned NQ           = 8;
   localparam int unsigned DEPTH        = 16;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct packed {
      wstd_pkg::rsp_status_type status;
      logic [15:0]              task_out;
      logic [2:0]               queue_used;
      logic                     wake;
   } dispatch_result_type;

   // DUT ports
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic        busy;
   logic [1:0]  req_command  = '0;
   logic [2:0]  req_worker   = '0;
   logic [15:0] req_task_id  = '0;
   logic        csr_wr_en    = 1'b0;
   logic [3:0]  csr_wr_data  = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_task_out;
   logic [2:0]  rsp_queue_used;
   logic        rsp_wake;

   // predictor state: per-queue FIFOs, worker states, round-robin pointer
   logic [15:0]                id_store [NQ][DEPTH];
   int unsigned                q_head [NQ];
   int unsigned                q_tail [NQ];
   int unsigned                q_fill [NQ];
   wstd_pkg::worker_state_type wk_state [NQ];
   int unsigned                rr_ptr;
   bit                         suspended_all;
   logic [3:0]                 workers_reg;

   dispatch_result_type pending_results[$];
   dispatch_result_type expected_head;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      gap_pct     = 0;
   int unsigned      sent_count  = 0;
   int unsigned      add_count   = 0;
   int unsigned      full_count  = 0;
   int unsigned      wake_count  = 0;
   int unsigned      req_count   = 0;
   int unsigned      steal_count = 0;
   int unsigned      sleep_count = 0;

   work_stealing_task_dispatcher dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_worker     (req_worker),
      .req_task_id    (req_task_id),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_task_out   (rsp_task_out),
      .rsp_queue_used (rsp_queue_used),
      .rsp_wake       (rsp_wake)
   );

   // 12-unit clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // effective queue count: 0 acts as 1, values above NQ saturate
   function automatic int unsigned active_workers();
      if (workers_reg == 0)
         return 1;
      if (workers_reg > NQ)
         return NQ;
      return int'(workers_reg);
   endfunction

   // Predict the response of one command and update the dispatcher state.
   function automatic dispatch_result_type dispatch_model(wstd_pkg::cmd_type cmd,
                                                          logic [2:0] w,
                                                          logic [15:0] id);
      dispatch_result_type r;
      int unsigned         n;
      int unsigned         q;
      int unsigned         i;
      bit                  found;
      r = '{status: wstd_pkg::RSP_DONE, task_out: '0, queue_used: '0, wake: 1'b0};
      n = active_workers();
      case (cmd)
         wstd_pkg::CMD_ADD: begin
            add_count++;
            q = rr_ptr % n;
            r.queue_used = 3'(q);
            if (q_fill[q] >= DEPTH) begin
               r.status = wstd_pkg::RSP_FULL;
               full_count++;
            end else begin
               if (q_fill[q] == 0 && wk_state[q] == wstd_pkg::WK_SLEEPING) begin
                  wk_state[q] = wstd_pkg::WK_WORKING;
                  r.wake = 1'b1;
                  wake_count++;
               end
               id_store[q][q_tail[q]] = id;
               q_tail[q] = (q_tail[q] + 1) % DEPTH;
               q_fill[q]++;
               rr_ptr = (q + 1) % n;
            end
         end
         wstd_pkg::CMD_REQUEST: begin
            req_count++;
            r.queue_used = w;
            if (w >= n || wk_state[w] != wstd_pkg::WK_WORKING) begin
               r.status = wstd_pkg::RSP_NOT_WORKING;
            end else begin
               found = 1'b0;
               // own queue first, then the following ones in circular order
               for (i = 0; i < n && !found; i++) begin
                  q = (w + i) % n;
                  if (q_fill[q] != 0) begin
                     r.task_out   = id_store[q][q_head[q]];
                     r.queue_used = 3'(q);
                     q_head[q] = (q_head[q] + 1) % DEPTH;
                     q_fill[q]--;
                     if (i != 0)
                        steal_count++;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  wk_state[w] = wstd_pkg::WK_SLEEPING;
                  r.status = wstd_pkg::RSP_SLEPT;
                  sleep_count++;
               end
            end
         end
         wstd_pkg::CMD_SUSPEND: begin
            if (suspended_all) begin
               r.status = wstd_pkg::RSP_NO_CHANGE;
            end else begin
               suspended_all = 1'b1;
               for (i = 0; i < n; i++)
                  wk_state[i] = wstd_pkg::WK_SUSPENDED;
            end
         end
         default: begin
            if (!suspended_all) begin
               r.status = wstd_pkg::RSP_NO_CHANGE;
            end else begin
               suspended_all = 1'b0;
               for (i = 0; i < n; i++)
                  wk_state[i] = wstd_pkg::WK_WORKING;
            end
         end
      endcase
      return r;
   endfunction

   // Drive one transaction from a falling edge, with a random lead-in gap,
   // and record its prediction at the accepting edge.
   task automatic issue(wstd_pkg::cmd_type cmd, logic [2:0] w, logic [15:0] id);
      if ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_command = cmd;
      req_worker  = w;
      req_task_id = id;
      start       = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_results.push_back(dispatch_model(cmd, w, id));
      sent_count++;
      @(negedge clock);
   endtask

   // Hold off until every expected response is in and the block is idle.
   task automatic settle();
      start = 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy)
         @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_workers(logic [3:0] value);
      settle();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      workers_reg = value;
   endtask

   task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // response checker: one transaction per strobe, in order
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("response with none outstanding: status %0d queue %0d",
                   rsp_status, rsp_queue_used);
            error_count++;
         end else begin
            expected_head = pending_results.pop_front();
            check_field("status", 16'(expected_head.status), 16'(rsp_status));
            check_field("task_out", expected_head.task_out, rsp_task_out);
            check_field("queue_used", 16'(expected_head.queue_used), 16'(rsp_queue_used));
            check_field("wake", 16'(expected_head.wake), 16'(rsp_wake));
         end
      end
   end

   // worker for a request: mostly a working active one, sometimes any index
   function automatic logic [2:0] pick_worker();
      int unsigned ready[$];
      int unsigned n;
      int unsigned i;
      n = active_workers();
      for (i = 0; i < n; i++)
         if (wk_state[i] == wstd_pkg::WK_WORKING)
            ready.push_back(i);
      if (ready.size() != 0 && $urandom_range(99) < 75)
         return 3'(ready[$urandom_range(ready.size() - 1)]);
      if ($urandom_range(99) < 70)
         return 3'($urandom_range(n - 1));
      return 3'($urandom_range(7));
   endfunction

   // Suspend/resume semantics from the sleeping state after reset.
   task automatic test_after_reset();
      issue(wstd_pkg::CMD_REQUEST, 3'd0, 16'd0);     // sleeping worker
      issue(wstd_pkg::CMD_RESUME, 3'd7, 16'hFFFF);   // not suspended: no change
      issue(wstd_pkg::CMD_SUSPEND, 3'd0, 16'd0);
      issue(wstd_pkg::CMD_SUSPEND, 3'd0, 16'd0);     // already suspended
      issue(wstd_pkg::CMD_REQUEST, 3'd2, 16'd0);     // suspended worker
      issue(wstd_pkg::CMD_ADD, 3'd0, 16'hFFFF);      // stored, no wake while suspended
      issue(wstd_pkg::CMD_RESUME, 3'd0, 16'd0);
      issue(wstd_pkg::CMD_RESUME, 3'd0, 16'd0);
   endtask

   // Own-queue pop, circular steal, sleep on empty, wake on add.
   task automatic test_steal_and_wake();
      issue(wstd_pkg::CMD_REQUEST, 3'd1, 16'd0);     // steals from queue 0, wrapping
      issue(wstd_pkg::CMD_REQUEST, 3'd1, 16'd0);     // everything empty: sleeps
      issue(wstd_pkg::CMD_ADD, 3'd0, 16'h0000);      // queue 1 wakes worker 1
      issue(wstd_pkg::CMD_ADD, 3'd0, 16'hAAAA);
      issue(wstd_pkg::CMD_ADD, 3'd0, 16'h5555);
      issue(wstd_pkg::CMD_REQUEST, 3'd2, 16'd0);     // own queue
      issue(wstd_pkg::CMD_REQUEST, 3'd2, 16'd0);     // steals from queue 3
      issue(wstd_pkg::CMD_REQUEST, 3'd7, 16'd0);     // steals from queue 1, wrapping
   endtask

   // Single active queue filled to the brim, then an inactive worker asks.
   task automatic test_queue_full();
      write_workers(4'd1);
      while (q_fill[0] < DEPTH)
         issue(wstd_pkg::CMD_ADD, 3'($urandom_range(7)), 16'($urandom_range(65535)));
      issue(wstd_pkg::CMD_ADD, 3'd0, 16'h1234);      // full
      issue(wstd_pkg::CMD_REQUEST, 3'd5, 16'd0);     // inactive worker
   endtask

   // Random traffic in chunks, each with its own worker count and add bias.
   task automatic test_random_traffic();
      logic [3:0]        settings [17];
      int unsigned       k;
      int unsigned       j;
      int unsigned       add_bias;
      int unsigned       pick;
      wstd_pkg::cmd_type cmd;
      settings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd9, 4'd5, 4'd1,
                   4'd7, 4'd4, 4'd6, 4'd8, 4'd2, 4'd12, 4'd0, 4'd8};
      for (k = 0; k < 17; k++) begin
         write_workers(settings[k]);
         gap_pct  = (k < 6) ? 9 : (k < 12) ? 80 : 0;
         add_bias = $urandom_range(25, 75);
         for (j = 0; j < 50; j++) begin
            // hold off for all responses now and then
            if (j == 25 && $urandom_range(99) < 40)
               settle();
            pick = $urandom_range(99);
            if (pick < 8) begin
               if (suspended_all)
                  cmd = ($urandom_range(99) < 85) ? wstd_pkg::CMD_RESUME :
                                                    wstd_pkg::CMD_SUSPEND;
               else
                  cmd = ($urandom_range(99) < 70) ? wstd_pkg::CMD_SUSPEND :
                                                    wstd_pkg::CMD_RESUME;
               issue(cmd, 3'($urandom_range(7)), 16'($urandom_range(65535)));
            end else if (pick < 8 + add_bias * 92 / 100) begin
               issue(wstd_pkg::CMD_ADD, 3'($urandom_range(7)),
                     16'($urandom_range(65535)));
            end else begin
               issue(wstd_pkg::CMD_REQUEST, pick_worker(), 16'($urandom_range(65535)));
            end
         end
      end
   endtask

   initial begin
      int unsigned i;
      // predictor reset state
      for (i = 0; i < NQ; i++) begin
         q_head[i]   = 0;
         q_tail[i]   = 0;
         q_fill[i]   = 0;
         wk_state[i] = wstd_pkg::WK_SLEEPING;
      end
      rr_ptr        = 0;
      suspended_all = 1'b0;
      workers_reg   = 4'(wstd_pkg::CSR_RESET);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_steal_and_wake();
      test_queue_full();
      test_random_traffic();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         error_count++;
      end
      $display("Ran %0d transactions: %0d adds (%0d full, %0d wakes), %0d requests",
               sent_count, add_count, full_count, wake_count, req_count);
      $display("  with %0d steals and %0d sleeps across 17 worker-count settings",
               steal_count, sleep_count);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
